@@ rtl/kau_pkg.sv @@
// ---------------------------------------------------------------------------
// kau_pkg
// shared types and constants of the k-means assign and update block
// ---------------------------------------------------------------------------
package kau_pkg;

    localparam int KAU_MAX_CLUSTERS = 8;
    localparam int KAU_DIMENSIONS   = 4;
    localparam int KAU_MAX_POINTS   = 4096;
    localparam int KAU_COORD_BITS   = 16;

    // field widths fixed by the stream format
    localparam int IDX_W   = 12;
    localparam int DIST_W  = 34;
    localparam int CNT_W   = 13;
    localparam int CLU_W   = 3;
    localparam int IO_COORDS = 4;
    localparam int IO_COORD_W = 16;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ASSIGN = 2'd1,
        FUNC_UPDATE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // register addresses
    localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;

    // one token travelling down the chain of cluster cells
    typedef struct packed {
        logic        valid;
        logic        upd;
        logic        found;
    } tok_ctl_t;

endpackage

@@ rtl/kmeans_assign_and_update.sv @@
// ---------------------------------------------------------------------------
// kmeans_assign_and_update
// one lloyd k-means pass: centroid load, point assign, centroid update
// ---------------------------------------------------------------------------
// load: taken with no result; assign: ST_DIST, then ST_SCAN over the active clusters,
// then ST_OUT, and the result is registered; update: per cluster with members, ST_DIV and
// ST_DWAIT per dimension on one shared divider, ST_DIV then ST_OUT for an empty one, plus any wait on m_tready
// throughput: one word at a time, next word taken the cycle after the last result goes
// reset: rst_n async low clears centroids, sums, counts, sets num_clusters to 8, then a
// clearing pass over all MAX_POINTS entries marks every point unassigned with s_tready low
module kmeans_assign_and_update #(
    parameter int MAX_CLUSTERS = kau_pkg::KAU_MAX_CLUSTERS,
    parameter int DIMENSIONS   = kau_pkg::KAU_DIMENSIONS,
    parameter int MAX_POINTS   = kau_pkg::KAU_MAX_POINTS,
    parameter int COORD_BITS   = kau_pkg::KAU_COORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], item_index[13:2], in_coord_0..3 [29:14]..[77:62], zero fill
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cluster[2:0], distance[36:3], changed[37], out_coord_0..3 [53:38]..[101:86],
    // member_count[114:102], zero fill
    output logic [119:0] m_tdata,
    output logic        m_tlast
);
    import kau_pkg::*;

    localparam int CW   = $clog2(MAX_CLUSTERS + 1) > 0 ? $clog2(MAX_CLUSTERS + 1) : 1;
    localparam int CI   = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DI   = DIMENSIONS > 1 ? $clog2(DIMENSIONS) : 1;
    localparam int PI   = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
    localparam int SUMW = COORD_BITS + CNT_W - 1;
    localparam int NUMW = SUMW;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIST  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_DWAIT = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // ---------------- configuration ----------------
    logic [3:0] ncl_reg;
    logic [CW-1:0] k_act;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ncl_reg <= 4'd8;
        else if (psel && penable && pwrite && paddr == REG_NUM_CLUSTERS[0:0])
            ncl_reg <= pwdata[3:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == REG_NUM_CLUSTERS[0:0]) ? {28'd0, ncl_reg} : 32'd0;
    always_comb
    begin
        if (ncl_reg == 4'd0)
            k_act = CW'(1);
        else if (32'(ncl_reg) > MAX_CLUSTERS)
            k_act = CW'(MAX_CLUSTERS);
        else
            k_act = CW'(ncl_reg);
    end

    // ---------------- input unpack ----------------
    func_t func_in;
    logic [IDX_W-1:0] idx_in;
    logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] pin;
    assign func_in = func_t'(s_tdata[1:0]);
    assign idx_in  = s_tdata[13:2];
    always_comb
    begin
        for (int d = 0; d < DIMENSIONS; d++)
            pin[d] = (d < IO_COORDS) ? COORD_BITS'(s_tdata[14 + 16*(d % IO_COORDS) +: 16])
                                     : '0;
    end

    // input held off during the clearing pass, outside ST_IDLE and while a result waits
    logic init_reg;
    logic s_acc;
    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid && !init_reg;
    assign s_acc    = s_tvalid && s_tready;

    logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] pt_reg;
    logic [IDX_W-1:0] idx_reg;
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            pt_reg  <= pin;
            idx_reg <= idx_in;
        end
    end

    // ---------------- chain of cluster cells ----------------
    logic [MAX_CLUSTERS-1:0] c_load, c_add, c_we;
    logic c_clr;
    logic [MAX_CLUSTERS-1:0][DIST_W-1:0] c_dist;
    logic signed [MAX_CLUSTERS-1:0][DIMENSIONS-1:0][COORD_BITS-1:0] c_cent;
    logic signed [MAX_CLUSTERS-1:0][DIMENSIONS-1:0][SUMW-1:0] c_sums;
    logic [MAX_CLUSTERS-1:0][CNT_W-1:0] c_cnt;
    logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] new_cent;

    genvar g;
    generate
        for (g = 0; g < MAX_CLUSTERS; g++)
        begin : g_cell
            kau_cell #(
                .DIMENSIONS(DIMENSIONS), .COORD_BITS(COORD_BITS), .DIST_BITS(DIST_W),
                .SUM_BITS(SUMW), .CNT_BITS(CNT_W), .MAX_POINTS(MAX_POINTS)
            ) u_cell (
                .clk(clk), .rst_n(rst_n),
                .load(c_load[g]), .add(c_add[g]), .clr(c_clr), .cent_we(c_we[g]),
                .cent_wd(c_load[g] ? pin : new_cent),
                .point(pt_reg),
                .sq_dist(c_dist[g]), .cent(c_cent[g]), .sums(c_sums[g]),
                .count(c_cnt[g])
            );
        end
    endgenerate

    always_comb
    begin
        for (int c = 0; c < MAX_CLUSTERS; c++)
            c_load[c] = s_acc && func_in == FUNC_LOAD && 32'(idx_in) == c;
    end

    // ---------------- scan / update control ----------------
    logic [CW-1:0] ci_reg, ci_next;
    logic [CI-1:0] ci;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [CI-1:0] bc_reg, bc_next;
    logic [DI-1:0] di_reg, di_next;
    logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] nc_reg;
    logic upd_reg;
    assign ci = ci_reg[CI-1:0];
    assign new_cent = nc_reg;

    // point assignment memory: valid bit above the cluster index
    logic [CI:0] amem [MAX_POINTS];
    logic [CI:0] ard_reg;
    logic [PI-1:0] init_addr_reg;
    logic [PI-1:0] pidx;
    logic pidx_ok;
    logic amem_we;
    assign pidx    = PI'(idx_reg);
    assign pidx_ok = 32'(idx_reg) < MAX_POINTS;
    assign amem_we = state_reg == ST_SCAN && ci_reg == k_act && pidx_ok;
    always_ff @(posedge clk)
    begin
        ard_reg <= amem[pidx];
        if (init_reg)
            amem[init_addr_reg] <= '0;
        else if (amem_we)
            amem[pidx] <= {1'b1, bc_reg};
    end

    // clearing pass, one entry per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b1;
            init_addr_reg <= '0;
        end
        else if (init_reg)
        begin
            if (init_addr_reg == PI'(MAX_POINTS - 1))
                init_reg <= 1'b0;
            init_addr_reg <= init_addr_reg + 1'b1;
        end
    end

    // divider over one cluster/dimension at a time
    logic div_start, div_done;
    logic signed [NUMW-1:0] div_q;
    kau_divider #(.NUM_W(NUMW), .DEN_W(CNT_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(c_sums[ci][di_reg]), .den(c_cnt[ci]),
        .done(div_done), .quot(div_q)
    );

    // output register
    logic mv_reg, mv_next;
    logic [119:0] md_reg, md_next;
    logic ml_reg, ml_next;

    always_comb
    begin
        state_next = state_reg;
        ci_next    = ci_reg;
        best_next  = best_reg;
        bc_next    = bc_reg;
        di_next    = di_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        c_add      = '0;
        c_we       = '0;
        c_clr      = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ci_next = '0;
                di_next = '0;
                if (s_acc && func_in == FUNC_ASSIGN)
                    state_next = ST_DIST;
                else if (s_acc && func_in == FUNC_UPDATE)
                    state_next = ST_DIV;
            end
            ST_DIST:
                state_next = ST_SCAN;   // squares registered in the cells
            ST_SCAN:
            begin
                if (ci_reg < k_act)
                begin
                    if (ci_reg == '0 || c_dist[ci] < best_reg)
                    begin
                        best_next = c_dist[ci];
                        bc_next   = ci;
                    end
                    ci_next = ci_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_OUT;
                    c_add[bc_reg] = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!upd_reg)
                begin
                    mv_next = 1'b1;
                    ml_next = 1'b1;
                    md_next = '0;
                    md_next[2:0]   = 3'(bc_reg);
                    md_next[36:3]  = best_reg;
                    md_next[37]    = pidx_ok && (!ard_reg[CI] || ard_reg[CI-1:0] != bc_reg);
                    md_next[114:102] = c_cnt[bc_reg];
                    state_next = ST_IDLE;
                end
                else if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    ml_next = (ci_reg == k_act - 1'b1);
                    md_next = '0;
                    md_next[2:0] = 3'(ci);
                    for (int d = 0; d < IO_COORDS; d++)
                        if (d < DIMENSIONS)
                            md_next[38 + 16*d +: 16] =
                                16'($signed(c_cnt[ci] != '0 ? nc_reg[d % DIMENSIONS]
                                                             : c_cent[ci][d % DIMENSIONS]));
                    md_next[114:102] = c_cnt[ci];
                    c_we[ci] = c_cnt[ci] != '0;
                    if (ci_reg == k_act - 1'b1)
                    begin
                        c_clr      = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ci_next    = ci_reg + 1'b1;
                        di_next    = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (c_cnt[ci] == '0)
                    state_next = ST_OUT;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DWAIT;
                end
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (32'(di_reg) == DIMENSIONS - 1)
                        state_next = ST_OUT;
                    else
                    begin
                        di_next    = di_reg + 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ci_reg    <= '0;
            di_reg    <= '0;
            mv_reg    <= 1'b0;
            upd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ci_reg    <= ci_next;
            di_reg    <= di_next;
            mv_reg    <= mv_next;
            if (s_acc)
                upd_reg <= func_in == FUNC_UPDATE;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        bc_reg   <= bc_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
        if (state_reg == ST_DWAIT && div_done)
            nc_reg[di_reg] <= COORD_BITS'(div_q);
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule

@@ rtl/kau_divider.sv @@
// ---------------------------------------------------------------------------
// kau_divider
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
module kau_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic signed [NUM_W-1:0] quot
);
    import kau_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] trial;
    logic [NUM_W-1:0] mag;

    assign mag = num[NUM_W-1] ? (~num + 1'b1) : num;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = mag;
            r_next    = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[NUM_W-1]} - {2'b00, d_reg};
            if (!trial[DEN_W+1])
            begin
                r_next = trial[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg   <= den;
            neg_reg <= num[NUM_W-1];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(~q_reg + 1'b1) : $signed(q_reg);

endmodule

@@ rtl/kau_cell.sv @@
// ---------------------------------------------------------------------------
// kau_cell
// one cluster cell: holds a centroid, its sums and count, computes distance
// ---------------------------------------------------------------------------
module kau_cell #(
    parameter int DIMENSIONS = 4,
    parameter int COORD_BITS = 16,
    parameter int DIST_BITS  = 34,
    parameter int SUM_BITS   = 28,
    parameter int CNT_BITS   = 13,
    parameter int MAX_POINTS = 4096
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     load,
    input  logic                                     add,
    input  logic                                     clr,
    input  logic                                     cent_we,
    input  logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] cent_wd,
    input  logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] point,
    output logic [DIST_BITS-1:0]                     sq_dist,
    output logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] cent,
    output logic signed [DIMENSIONS-1:0][SUM_BITS-1:0]   sums,
    output logic [CNT_BITS-1:0]                      count
);
    import kau_pkg::*;

    logic signed [DIMENSIONS-1:0][COORD_BITS-1:0] cent_reg;
    logic signed [DIMENSIONS-1:0][SUM_BITS-1:0]   sum_reg;
    logic [CNT_BITS-1:0]                          cnt_reg;
    logic [DIMENSIONS-1:0][2*COORD_BITS+1:0]      sq;

    // square of one signed coordinate difference
    function automatic logic [2*COORD_BITS+1:0] sq_term(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0]     df;
        logic signed [2*COORD_BITS+1:0] pr;
        df = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        pr = df * df;
        return pr;
    endfunction

    // squared difference per dimension, registered before the sum
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < DIMENSIONS; d++)
            sq[d] <= sq_term(point[d], cent_reg[d]);
    end

    always_comb
    begin
        sq_dist = '0;
        for (int d = 0; d < DIMENSIONS; d++)
            sq_dist = sq_dist + DIST_BITS'(sq[d]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cent_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (load || cent_we)
                cent_reg <= cent_wd;
            if (clr)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else if (add && cnt_reg < CNT_BITS'(MAX_POINTS))
            begin
                for (int d = 0; d < DIMENSIONS; d++)
                    sum_reg[d] <= sum_reg[d] + SUM_BITS'($signed(point[d]));
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign cent  = cent_reg;
    assign sums  = sum_reg;
    assign count = cnt_reg;

endmodule

@@ rtl/kau_checker.sv @@
// ---------------------------------------------------------------------------
// kau_checker
// port-level checks of the k-means block
// ---------------------------------------------------------------------------
module kau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic         m_tlast
);
    // no new word taken while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken while output pending");
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped");
    // padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[119:115] == 5'd0) else $error("padding set");
    // no result in the cycle right after a word is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind kmeans_assign_and_update kau_checker u_kau_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

@@ sim/tb_kmeans_assign_and_update.sv @@
// ---------------------------------------------------------------------------
// tb_kmeans_assign_and_update
// self-checking bench: random centroid loads, point assigns and updates are
// streamed in, every result word is checked against an in-bench predictor
// ---------------------------------------------------------------------------
module tb_kmeans_assign_and_update;
    timeunit 1ns;
    timeprecision 1ps;
    import kau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  cluster;
        logic [33:0] distance;
        logic        changed;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [12:0] member_count;
        logic        last;
    } kres_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [0:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         m_tlast;

    kmeans_assign_and_update u_top (.*);

    // predictor state
    logic signed [15:0] cent_mem [8][4];
    longint             sum_mem [8][4];
    int                 count_mem [8];
    logic [2:0]         assign_mem [4096];
    bit                 assign_ok [4096];
    int                 k_active;

    logic [79:0] word_q [$];
    kres_t       expect_q [$];
    int          errors = 0;
    int          sent_words = 0;
    int          got_words = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles = 0;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor: applied at the moment a word is queued for sending
    // ------------------------------------------------------------------
    function automatic logic [79:0] pack_word(func_t f, int idx, int a, int b, int c,
                                              int d);
        return {2'b00, d[15:0], c[15:0], b[15:0], a[15:0], idx[11:0], f};
    endfunction

    task automatic predict_kmeans(logic [79:0] w);
        func_t       f;
        int          idx;
        logic signed [15:0] p [4];
        longint      best;
        longint      sq_sum;
        longint      df;
        int          bc;
        kres_t       r;
        f = func_t'(w[1:0]);
        idx = int'(w[13:2]);
        for (int d = 0; d < 4; d++)
            p[d] = w[14 + 16*d +: 16];
        if (f == FUNC_LOAD)
        begin
            if (idx < 8)
                for (int d = 0; d < 4; d++)
                    cent_mem[idx][d] = p[d];
        end
        else if (f == FUNC_ASSIGN)
        begin
            best = 0;
            bc = 0;
            for (int c = 0; c < k_active; c++)
            begin
                sq_sum = 0;
                for (int d = 0; d < 4; d++)
                begin
                    df = longint'(p[d]) - longint'(cent_mem[c][d]);
                    sq_sum += df * df;
                end
                if (c == 0 || sq_sum < best)
                begin
                    best = sq_sum;
                    bc = c;
                end
            end
            r = '0;
            r.changed = !assign_ok[idx] || assign_mem[idx] != bc;
            assign_ok[idx] = 1'b1;
            assign_mem[idx] = 3'(bc);
            if (count_mem[bc] < 4096)
            begin
                for (int d = 0; d < 4; d++)
                    sum_mem[bc][d] += p[d];
                count_mem[bc]++;
            end
            r.cluster = 3'(bc);
            r.distance = best[33:0];
            r.member_count = 13'(count_mem[bc]);
            r.last = 1'b1;
            expect_q = {expect_q, r};
        end
        else if (f == FUNC_UPDATE)
        begin
            for (int c = 0; c < k_active; c++)
            begin
                r = '0;
                if (count_mem[c] > 0)
                    for (int d = 0; d < 4; d++)
                        cent_mem[c][d] = 16'(sum_mem[c][d] / count_mem[c]);
                r.cluster = 3'(c);
                r.c0 = cent_mem[c][0];
                r.c1 = cent_mem[c][1];
                r.c2 = cent_mem[c][2];
                r.c3 = cent_mem[c][3];
                r.member_count = 13'(count_mem[c]);
                r.last = (c == k_active - 1);
                expect_q = {expect_q, r};
            end
            for (int c = 0; c < 8; c++)
            begin
                count_mem[c] = 0;
                for (int d = 0; d < 4; d++)
                    sum_mem[c][d] = 0;
            end
        end
    endtask

    task automatic queue_word(logic [79:0] w);
        predict_kmeans(w);
        word_q = {word_q, w};
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return int'($urandom_range(0, 40)) - 20;
            default: return int'($urandom);
        endcase
    endfunction

    // point index mostly small so assignments repeat and changed goes both ways
    task automatic queue_random(bit noisy);
        func_t f;
        int    idx;
        int    sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            f = FUNC_LOAD;
        else if (sel < 14)
            f = FUNC_UPDATE;
        else if (noisy && sel < 17)
            f = FUNC_NONE;
        else
            f = FUNC_ASSIGN;
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, 31);
        if (f == FUNC_LOAD && $urandom_range(0, 4) != 0)
            idx = $urandom_range(0, 7);
        queue_word(pack_word(f, idx, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord()));
    endtask

    // ------------------------------------------------------------------
    // register access, only while the block is idle
    // ------------------------------------------------------------------
    task automatic write_num_clusters(int val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_NUM_CLUSTERS[0:0];
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        k_active = (val & 15) == 0 ? 1 : ((val & 15) > 8 ? 8 : (val & 15));
    endtask

    task automatic drain();
        wait (word_q.size() == 0 && !s_tvalid && expect_q.size() == 0);
        // a trailing load gives no result, so allow its latency
        repeat (20) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: one word from the queue, held until accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
            if (!s_tvalid || s_tready)
            begin
                if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tdata <= word_q.pop_front();
                    s_tvalid <= 1'b1;
                    sent_words <= sent_words + 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        kres_t e;
        kres_t a;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_words <= got_words + 1;
            a = {m_tdata[2:0], m_tdata[36:3], m_tdata[37], m_tdata[53:38],
                 m_tdata[69:54], m_tdata[85:70], m_tdata[101:86],
                 m_tdata[114:102], m_tlast};
            if (expect_q.size() == 0)
            begin
                $display("%0t unexpected result word %h", $time, a);
                errors <= errors + 1;
            end
            else
            begin
                e = expect_q.pop_front();
                if (a.cluster !== e.cluster || a.distance !== e.distance ||
                    a.changed !== e.changed || a.c0 !== e.c0 || a.c1 !== e.c1 ||
                    a.c2 !== e.c2 || a.c3 !== e.c3 ||
                    a.member_count !== e.member_count || a.last !== e.last)
                begin
                    $display("%0t mismatch: expected cl=%0d d=%0d ch=%0d c=%h/%h/%h/%h n=%0d l=%0d",
                             $time, e.cluster, e.distance, e.changed, e.c0, e.c1,
                             e.c2, e.c3, e.member_count, e.last);
                    $display("%0t            actual cl=%0d d=%0d ch=%0d c=%h/%h/%h/%h n=%0d l=%0d",
                             $time, a.cluster, a.distance, a.changed, a.c0, a.c1,
                             a.c2, a.c3, a.member_count, a.last);
                    errors <= errors + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int settings [4];
        settings = '{3, 1, 8, 0};
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 1'b0; pwdata = '0;
        send_idle_pct = 8;
        recv_idle_pct = 52;
        k_active = 8;
        for (int c = 0; c < 8; c++)
        begin
            count_mem[c] = 0;
            for (int d = 0; d < 4; d++)
            begin
                cent_mem[c][d] = 0;
                sum_mem[c][d] = 0;
            end
        end
        for (int i = 0; i < 4096; i++)
        begin
            assign_ok[i] = 0;
            assign_mem[i] = 0;
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset centroids, ties, extremes, ignored codes
        queue_word(pack_word(FUNC_ASSIGN, 0, 0, 0, 0, 0));          // tie at zero
        queue_word(pack_word(FUNC_LOAD, 1, 32767, 32767, 32767, 32767));
        queue_word(pack_word(FUNC_LOAD, 2, -32768, -32768, -32768, -32768));
        queue_word(pack_word(FUNC_LOAD, 9, 1, 2, 3, 4));            // index ignored
        queue_word(pack_word(FUNC_ASSIGN, 4095, -32768, -32768, -32768, -32768));
        queue_word(pack_word(FUNC_ASSIGN, 0, 32767, 32767, 32767, 32767));
        queue_word(pack_word(FUNC_ASSIGN, 0, 32767, 32767, 32767, 32767));
        queue_word(pack_word(FUNC_NONE, 5, 1, 1, 1, 1));            // unused code
        queue_word(pack_word(FUNC_ASSIGN, 7, -3, -5, 7, 1));
        queue_word(pack_word(FUNC_ASSIGN, 8, -4, -6, 9, 2));
        queue_word(pack_word(FUNC_UPDATE, 0, 0, 0, 0, 0));          // empty clusters kept
        queue_word(pack_word(FUNC_UPDATE, 4095, 0, 0, 0, 0));       // all empty
        queue_word(pack_word(FUNC_ASSIGN, 0, -32768, 32767, -32768, 32767));
        drain();

        // random phases across register settings and idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            write_num_clusters(settings[ph]);
            if (ph == 1)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 8;
            end
            else if (ph >= 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 8; i++)
                queue_word(pack_word(FUNC_LOAD, i, rand_coord(), rand_coord(),
                                     rand_coord(), rand_coord()));
            for (int i = 0; i < 105; i++)
                queue_random(i % 10 == 0);
            queue_word(pack_word(FUNC_UPDATE, 0, 0, 0, 0, 0));
            drain();
        end

        $display("sent %0d input words over cluster counts 3, 1, 8 and 0", sent_words);
        $display("checked %0d result words under three idle mixes", got_words);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ kmeans_assign_and_update.f @@
rtl/kau_pkg.sv
rtl/kau_divider.sv
rtl/kau_cell.sv
rtl/kmeans_assign_and_update.sv
rtl/kau_checker.sv
sim/tb_kmeans_assign_and_update.sv
